>>> rtl/alnorm_pkg.sv
package alnorm_pkg;

	// Layer count of the blend stack, base coat included.
	localparam int MAX_LAYERS = 4;

	// Layers above the base coat that carry a coverage byte; one lane each.
	localparam int LANES = 3;

	// Effective layer count is capped by both the stack size and the lanes present.
	localparam int N_CAP = (MAX_LAYERS < LANES + 1) ? MAX_LAYERS : LANES + 1;

	localparam int ALPHA_W    = 8;
	localparam int COUNT_W    = 3;
	localparam int EDIT_W     = 2;
	localparam int SUM_W      = 10;
	localparam int NUM_W      = 16;
	localparam int QUO_W      = 8;
	localparam int TRIAL_W    = SUM_W + QUO_W;
	localparam int BITS_PER_STAGE = 2;
	localparam int DIV_STAGES = QUO_W / BITS_PER_STAGE;

	// Prep stage, multiply stage, divider stages.
	localparam int NUM_STAGES = 2 + DIV_STAGES;

	localparam logic [ALPHA_W-1:0] ALPHA_MAX = 8'd255;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_LAYER_COUNT  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EDITED_LAYER = 1'd1;

	typedef struct packed {
		logic [ALPHA_W-1:0] alpha_one;
		logic [ALPHA_W-1:0] alpha_two;
		logic [ALPHA_W-1:0] alpha_three;
	} texel_t;

	typedef struct packed {
		logic [ALPHA_W-1:0] out_alpha_one;
		logic [ALPHA_W-1:0] out_alpha_two;
		logic [ALPHA_W-1:0] out_alpha_three;
		logic               was_scaled;
	} result_t;

	// What the prep stage hands to the lanes; lane 0 is layer one.
	typedef struct packed {
		logic [LANES-1:0][ALPHA_W-1:0] alpha;
		logic [LANES-1:0]              rescale;
		logic [SUM_W-1:0]              denom;
		logic [ALPHA_W-1:0]            scale;
		logic                          scaled;
	} prep_t;

	// Load enables for the stages that live inside a lane.
	typedef struct packed {
		logic                  mul_en;
		logic [DIV_STAGES-1:0] div_en;
	} lane_ctl_t;

endpackage

>>> rtl/alnorm_prep.sv
module alnorm_prep
	import alnorm_pkg::*;
(
	input  logic               clk,
	input  logic               en,
	input  logic [COUNT_W-1:0] layer_count,
	input  logic [EDIT_W-1:0]  edited_layer,
	input  texel_t             texel,
	output prep_t              prep_s1
);

	logic [COUNT_W-1:0]            n_eff;
	logic [LANES-1:0][ALPHA_W-1:0] alpha;
	logic [LANES-1:0]              in_use;
	logic [LANES-1:0]              ed_hit;
	logic [SUM_W-1:0]              sum;
	logic [ALPHA_W-1:0]            ed_val;
	logic                          scaled;
	prep_t                         prep_n;

	assign alpha[0] = texel.alpha_one;
	assign alpha[1] = texel.alpha_two;
	assign alpha[2] = texel.alpha_three;

	always_comb begin
		n_eff  = (layer_count > COUNT_W'(N_CAP)) ? COUNT_W'(N_CAP) : layer_count;
		sum    = '0;
		ed_val = '0;
		for (int i = 0; i < LANES; i++) begin
			in_use[i] = COUNT_W'(i + 1) < n_eff;
			ed_hit[i] = in_use[i] && (edited_layer == EDIT_W'(i + 1));
			if (in_use[i]) begin
				sum = sum + SUM_W'(alpha[i]);
			end
			if (ed_hit[i]) begin
				ed_val = alpha[i];
			end
		end
		scaled = sum > SUM_W'(ALPHA_MAX);
		for (int i = 0; i < LANES; i++) begin
			prep_n.rescale[i] = scaled && in_use[i] && !ed_hit[i];
		end
		prep_n.alpha  = alpha;
		prep_n.denom  = sum - SUM_W'(ed_val);
		prep_n.scale  = ALPHA_MAX - ed_val;
		prep_n.scaled = scaled;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prep_s1 <= prep_n;
		end
	end

endmodule

>>> rtl/alnorm_lane.sv
module alnorm_lane
	import alnorm_pkg::*;
(
	input  logic               clk,
	input  lane_ctl_t          ctl,
	input  logic [ALPHA_W-1:0] alpha,
	input  logic               rescale,
	input  logic [SUM_W-1:0]   denom,
	input  logic [ALPHA_W-1:0] scale,
	output logic [ALPHA_W-1:0] value
);

	// Multiply stage.
	logic [NUM_W-1:0]   num_s2;
	logic [SUM_W-1:0]   den_s2;
	logic [ALPHA_W-1:0] alpha_s2;
	logic               rescale_s2;

	// Divider stages, one entry per stage.
	logic [NUM_W-1:0]   rem_s     [DIV_STAGES];
	logic [QUO_W-1:0]   quo_s     [DIV_STAGES];
	logic [SUM_W-1:0]   den_s     [DIV_STAGES];
	logic [ALPHA_W-1:0] alpha_s   [DIV_STAGES];
	logic               rescale_s [DIV_STAGES];

	logic [NUM_W-1:0]   rem_n [DIV_STAGES];
	logic [QUO_W-1:0]   quo_n [DIV_STAGES];

	// Numerator with the round-half-up bias; at most 255*255 + 382, so it fits.
	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			num_s2     <= NUM_W'(alpha) * NUM_W'(scale) + NUM_W'(denom >> 1);
			den_s2     <= denom;
			alpha_s2   <= alpha;
			rescale_s2 <= rescale;
		end
	end

	// Restoring division, two quotient bits per stage, most significant first.
	always_comb begin
		logic [NUM_W-1:0]   r;
		logic [QUO_W-1:0]   q;
		logic [SUM_W-1:0]   d;
		logic [TRIAL_W-1:0] trial;
		int                 k;
		for (int j = 0; j < DIV_STAGES; j++) begin
			r = (j == 0) ? num_s2 : rem_s[j-1];
			q = (j == 0) ? '0 : quo_s[j-1];
			d = (j == 0) ? den_s2 : den_s[j-1];
			for (int b = 0; b < BITS_PER_STAGE; b++) begin
				k     = QUO_W - 1 - j * BITS_PER_STAGE - b;
				trial = TRIAL_W'(d) << k;
				if (TRIAL_W'(r) >= trial) begin
					r    = r - NUM_W'(trial);
					q[k] = 1'b1;
				end
			end
			rem_n[j] = r;
			quo_n[j] = q;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < DIV_STAGES; j++) begin
			if (ctl.div_en[j]) begin
				rem_s[j]     <= rem_n[j];
				quo_s[j]     <= quo_n[j];
				den_s[j]     <= (j == 0) ? den_s2 : den_s[j-1];
				alpha_s[j]   <= (j == 0) ? alpha_s2 : alpha_s[j-1];
				rescale_s[j] <= (j == 0) ? rescale_s2 : rescale_s[j-1];
			end
		end
	end

	// A rescaled layer is never larger than the divisor, so the quotient stays
	// at or below 255 and needs no clamp.
	assign value = rescale_s[DIV_STAGES-1] ? quo_s[DIV_STAGES-1] : alpha_s[DIV_STAGES-1];

endmodule

>>> rtl/alpha_layer_normalizer_unit.sv
// Alpha layer normalizer.
// One transaction on the texel channel carries the coverage bytes of layers
// one to three of a texel; one transaction on the result channel returns the
// normalized bytes plus a flag that tells whether rescaling took place.
// Both channels use valid and stall: a transaction completes at a rising edge
// with valid high and stall low. The texel is taken into the prep stage, which
// sums the layers in use and derives divisor and scale; three lanes then each
// multiply and divide one layer, and the result register merges the lanes.
// Throughput: one texel per cycle while the result receiver does not stall,
// set by the pipelined lane divider, which resolves two quotient bits per
// stage over four stages.
// When the result receiver stalls, every stage holds that has a valid
// transaction in front of it that cannot move; bubbles still close up, and
// texel_stall rises only when the whole pipeline is full.
// The configuration port writes layer_count (index 0) and edited_layer
// (index 1) at any edge with cfg_we high; it is meant to be used while the
// pipeline is empty. Reset empties the pipeline and sets layer_count to 1
// and edited_layer to 0.
module alpha_layer_normalizer_unit
	import alnorm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  texel_valid,
	output logic                  texel_stall,
	input  texel_t                texel,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [COUNT_W-1:0]              layer_count_q;
	logic [EDIT_W-1:0]               edited_layer_q;

	// Valid bit of each stage: prep, multiply, then the divider stages.
	logic [NUM_STAGES-1:0]           stage_valid_q;
	logic [NUM_STAGES-1:0]           advance;
	logic                            out_en;

	// The scaled flag rides beside the lanes from the multiply stage onward.
	logic [NUM_STAGES-1:1]           scaled_q;

	prep_t                           prep_s1;
	lane_ctl_t                       lane_ctl;
	logic [LANES-1:0][ALPHA_W-1:0]   lane_value;

	logic                            result_valid_q;
	result_t                         result_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layer_count_q  <= COUNT_W'(1);
			edited_layer_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LAYER_COUNT:  layer_count_q  <= cfg_data[COUNT_W-1:0];
				REG_EDITED_LAYER: edited_layer_q <= cfg_data[EDIT_W-1:0];
				default: ;
			endcase
		end
	end

	// A stage may load when it is empty or when the stage after it moves on.
	// The result register moves when it is empty or its transaction is taken.
	always_comb begin
		out_en                  = !result_valid_q || !result_stall;
		advance[NUM_STAGES-1]   = !stage_valid_q[NUM_STAGES-1] || out_en;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			advance[k] = !stage_valid_q[k] || advance[k+1];
		end
	end

	assign texel_stall     = !advance[0];
	assign lane_ctl.mul_en = advance[1];
	assign lane_ctl.div_en = advance[NUM_STAGES-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q  <= '0;
			result_valid_q <= 1'b0;
		end else begin
			for (int k = 0; k < NUM_STAGES; k++) begin
				if (advance[k]) begin
					stage_valid_q[k] <= (k == 0) ? texel_valid : stage_valid_q[k-1];
				end
			end
			if (out_en) begin
				result_valid_q <= stage_valid_q[NUM_STAGES-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 1; k < NUM_STAGES; k++) begin
			if (advance[k]) begin
				scaled_q[k] <= (k == 1) ? prep_s1.scaled : scaled_q[k-1];
			end
		end
	end

	alnorm_prep u_prep (
		.clk          (clk),
		.en           (advance[0]),
		.layer_count  (layer_count_q),
		.edited_layer (edited_layer_q),
		.texel        (texel),
		.prep_s1      (prep_s1)
	);

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		alnorm_lane u_lane (
			.clk     (clk),
			.ctl     (lane_ctl),
			.alpha   (prep_s1.alpha[i]),
			.rescale (prep_s1.rescale[i]),
			.denom   (prep_s1.denom),
			.scale   (prep_s1.scale),
			.value   (lane_value[i])
		);
	end

	// Merge stage: gather the three lanes and the flag into the result register.
	always_ff @(posedge clk) begin
		if (out_en && stage_valid_q[NUM_STAGES-1]) begin
			result_q.out_alpha_one   <= lane_value[0];
			result_q.out_alpha_two   <= lane_value[1];
			result_q.out_alpha_three <= lane_value[2];
			result_q.was_scaled      <= scaled_q[NUM_STAGES-1];
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

>>> tb/tb_alpha_layer_normalizer_unit.sv
`timescale 1ns / 1ps

// Testbench for the alpha layer normalizer.
// Texels go in on the valid/stall channel, one transaction at a time, from a
// set of named tests. Each accepted texel is run through a predictor of the
// normalization, and the outcome is queued. A checker process pops the oldest
// queued outcome for every result transaction and compares it field by field.
// Both sides idle at random: the texel side leaves gaps between transactions
// and the result side raises stall in runs of random length.
module tb_alpha_layer_normalizer_unit;
	import alnorm_pkg::*;

	// The slowest legal run is about 1600 texels times (longest texel gap plus
	// longest stall run plus pipeline depth), plus the pauses around the
	// configuration writes.
	localparam int CYCLE_LIMIT  = 1_000_000;
	// This leaves a margin on top of the pipeline latency.
	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_TEXELS = 1550;

	logic                  clk;
	logic                  arst_n;
	logic                  texel_valid;
	logic                  texel_stall;
	texel_t                texel;
	logic                  result_valid;
	logic                  result_stall;
	result_t               result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Outcomes that the predictor worked out for accepted texels, oldest first.
	result_t               normalized_queue[$];

	// The predictor's own copy of the two configuration registers.
	logic [COUNT_W-1:0]    layer_count_q;
	logic [EDIT_W-1:0]     edited_layer_q;

	int                    error_count;
	int                    cycle_count;
	int                    stall_run;
	int                    free_run;
	bit                    tx_quiet;
	bit                    rx_quiet;

	alpha_layer_normalizer_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.texel_valid  (texel_valid),
		.texel_stall  (texel_stall),
		.texel        (texel),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	// Predicts the normalized coverage of one texel under the current register
	// values. Layer zero is the base coat and always counts as fully opaque,
	// but it never takes part in the sum.
	function automatic result_t normalize_texel(input texel_t t);
		int unsigned layer[4];
		int unsigned in_use;
		int unsigned total;
		int unsigned kept;
		int unsigned denom;
		int unsigned scale;
		int unsigned q;
		bit          rescaled;
		result_t     r;
		layer[0] = ALPHA_MAX;
		layer[1] = t.alpha_one;
		layer[2] = t.alpha_two;
		layer[3] = t.alpha_three;
		total    = 0;
		kept     = 0;
		rescaled = 1'b0;
		// The count saturates at the stack size and at the lanes that exist.
		in_use = layer_count_q;
		if (in_use > MAX_LAYERS) begin
			in_use = MAX_LAYERS;
		end
		if (in_use > LANES + 1) begin
			in_use = LANES + 1;
		end
		if (in_use > 1) begin
			for (int i = 1; i < in_use; i++) begin
				total += layer[i];
			end
			if (total > ALPHA_MAX) begin
				// An edited index of zero or past the count preserves nothing.
				if (edited_layer_q >= 1 && edited_layer_q < in_use) begin
					kept = layer[edited_layer_q];
				end
				denom = total - kept;
				scale = ALPHA_MAX - kept;
				for (int i = 1; i < in_use; i++) begin
					if (i != edited_layer_q) begin
						q        = (layer[i] * scale + denom / 2) / denom;
						layer[i] = (q > ALPHA_MAX) ? ALPHA_MAX : q;
					end
				end
				rescaled = 1'b1;
			end
		end
		r.out_alpha_one   = layer[1][ALPHA_W-1:0];
		r.out_alpha_two   = layer[2][ALPHA_W-1:0];
		r.out_alpha_three = layer[3][ALPHA_W-1:0];
		r.was_scaled      = rescaled;
		return r;
	endfunction

	// Gap before a texel: mostly none, sometimes a few cycles, rarely a long one.
	function automatic int pick_texel_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (tx_quiet || r < 70) begin
			return 0;
		end else if (r < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// Offers one texel and holds it until the unit takes it. Valid stays high
	// afterwards so that a following call can keep the channel busy; anything
	// else that lets time pass lowers it first.
	task automatic send_texel(input logic [ALPHA_W-1:0] a1, input logic [ALPHA_W-1:0] a2,
			input logic [ALPHA_W-1:0] a3);
		texel_t t;
		int     gap;
		t.alpha_one   = a1;
		t.alpha_two   = a2;
		t.alpha_three = a3;
		gap = pick_texel_gap();
		if (gap > 0) begin
			texel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		texel_valid <= 1'b1;
		texel       <= t;
		do begin
			@(posedge clk);
		end while (texel_stall);
		normalized_queue = {normalized_queue, normalize_texel(t)};
	endtask

	// Waits until the pipeline has drained, then writes both registers.
	task automatic set_config(input logic [COUNT_W-1:0] count, input logic [EDIT_W-1:0] edited);
		texel_valid <= 1'b0;
		while (normalized_queue.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_LAYER_COUNT;
		cfg_data  <= CFG_DATA_W'(count);
		@(posedge clk);
		cfg_index <= REG_EDITED_LAYER;
		cfg_data  <= CFG_DATA_W'(edited);
		@(posedge clk);
		cfg_we         <= 1'b0;
		layer_count_q  = count;
		edited_layer_q = edited;
	endtask

	// Right after reset the unit must treat only the base coat as in use, so
	// every texel passes through untouched.
	task automatic test_reset_values();
		send_texel(8'd255, 8'd255, 8'd255);
		send_texel(8'd0, 8'd0, 8'd0);
		send_texel(8'd170, 8'd85, 8'd1);
	endtask

	// All three layers in use with nothing preserved: sums on both sides of the
	// rescale threshold and at the byte extremes.
	task automatic test_sum_threshold();
		set_config(3'd4, 2'd0);
		send_texel(8'd85, 8'd85, 8'd85);
		send_texel(8'd86, 8'd85, 8'd85);
		send_texel(8'd255, 8'd255, 8'd255);
		send_texel(8'd0, 8'd0, 8'd0);
		send_texel(8'd1, 8'd2, 8'd253);
		send_texel(8'd100, 8'd101, 8'd102);
		send_texel(8'd128, 8'd128, 8'd0);
	endtask

	// The edited layer keeps its stroke while the others shrink around it.
	task automatic test_edited_layer();
		set_config(3'd4, 2'd1);
		// A fully covered edited layer leaves a divisor of one and a scale of zero.
		send_texel(8'd255, 8'd1, 8'd0);
		send_texel(8'd200, 8'd100, 8'd50);
		set_config(3'd4, 2'd2);
		send_texel(8'd10, 8'd250, 8'd250);
		set_config(3'd4, 2'd3);
		send_texel(8'd0, 8'd255, 8'd255);
		// With three layers in use, index three points past the count and is ignored.
		set_config(3'd3, 2'd3);
		send_texel(8'd200, 8'd200, 8'd200);
	endtask

	// Counts of zero, two and three, and counts that saturate at the stack size.
	task automatic test_layer_count_range();
		set_config(3'd0, 2'd0);
		send_texel(8'd255, 8'd255, 8'd255);
		set_config(3'd2, 2'd1);
		send_texel(8'd255, 8'd255, 8'd255);
		set_config(3'd3, 2'd1);
		// Layer three lies beyond the count and must come back as it went in.
		send_texel(8'd255, 8'd1, 8'd77);
		set_config(3'd5, 2'd2);
		send_texel(8'd90, 8'd200, 8'd30);
		set_config(3'd7, 2'd3);
		send_texel(8'd255, 8'd255, 8'd255);
	endtask

	function automatic logic [ALPHA_W-1:0] pick_edge_byte();
		case ($urandom_range(0, 3))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd254;
			default: return 8'd255;
		endcase
	endfunction

	// Phases of random texels, each under a fresh register setting. The texel
	// mix leans on sums near and above the threshold, where the arithmetic lives.
	task automatic test_random_traffic();
		int          sent;
		int          phase_len;
		int          style;
		int          tail;
		logic [7:0]  a1;
		logic [7:0]  a2;
		logic [7:0]  a3;
		logic [COUNT_W-1:0] count;
		sent = 0;
		while (sent < RANDOM_TEXELS) begin
			count = ($urandom_range(0, 9) < 6) ? COUNT_W'($urandom_range(2, 4))
			                                   : COUNT_W'($urandom_range(0, 7));
			set_config(count, EDIT_W'($urandom_range(0, 3)));
			tx_quiet  = ($urandom_range(0, 4) == 0);
			rx_quiet  = ($urandom_range(0, 4) == 0);
			phase_len = $urandom_range(40, 160);
			for (int k = 0; k < phase_len && sent < RANDOM_TEXELS; k++) begin
				style = $urandom_range(0, 9);
				a1 = 8'($urandom_range(0, 255));
				a2 = 8'($urandom_range(0, 255));
				a3 = 8'($urandom_range(0, 255));
				if (style == 4 || style == 5) begin
					// Light coverage that often stays under the threshold.
					a1 = 8'($urandom_range(0, 90));
					a2 = 8'($urandom_range(0, 90));
					a3 = 8'($urandom_range(0, 90));
				end else if (style == 6) begin
					// A sum of 255, 256 or 257 across all three layers.
					a1   = 8'($urandom_range(0, 127));
					a2   = 8'($urandom_range(0, 127));
					tail = 255 - a1 - a2 + $urandom_range(0, 2);
					a3   = (tail > 255) ? 8'd255 : tail[7:0];
				end else if (style == 7) begin
					a1 = pick_edge_byte();
					a2 = pick_edge_byte();
					a3 = pick_edge_byte();
				end else if (style >= 8) begin
					// One layer fully covered, which makes for tiny divisors.
					case ($urandom_range(0, 2))
						0: a1 = 8'd255;
						1: a2 = 8'd255;
						default: a3 = 8'd255;
					endcase
				end
				send_texel(a1, a2, a3);
				sent++;
			end
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	task automatic report_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		end
	endtask

	// Result checker. The stall value read here is the one the unit saw at
	// this edge, since the new one is only scheduled below.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (normalized_queue.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result transaction, expected none, actual %h",
					$time, result);
			end else begin
				want = normalized_queue.pop_front();
				report_field("out_alpha_one", want.out_alpha_one, result.out_alpha_one);
				report_field("out_alpha_two", want.out_alpha_two, result.out_alpha_two);
				report_field("out_alpha_three", want.out_alpha_three, result.out_alpha_three);
				report_field("was_scaled", want.was_scaled, result.was_scaled);
			end
		end
	end

	// Result-side stall. Free runs alternate with stall runs; most stall runs
	// are short and a few are long, and some free runs are long stretches of
	// uninterrupted flow.
	always @(posedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else if (stall_run > 0) begin
			result_stall <= 1'b1;
			stall_run--;
		end else if (free_run > 0) begin
			result_stall <= 1'b0;
			free_run--;
		end else begin
			result_stall <= 1'b0;
			if (rx_quiet) begin
				free_run  = 50;
				stall_run = 0;
			end else begin
				free_run  = ($urandom_range(0, 9) < 2) ? $urandom_range(40, 200)
				                                      : $urandom_range(0, 4);
				stall_run = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
				                                        : $urandom_range(10, 40);
			end
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("alpha_layer_normalizer_unit verification failed");
			$finish;
		end
	end

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		texel_valid    = 1'b0;
		texel          = '0;
		result_stall   = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = REG_LAYER_COUNT;
		cfg_data       = '0;
		layer_count_q  = 3'd1;
		edited_layer_q = 2'd0;
		error_count    = 0;
		cycle_count    = 0;
		stall_run      = 0;
		free_run       = 0;
		tx_quiet       = 1'b0;
		rx_quiet       = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_sum_threshold();
		test_edited_layer();
		test_layer_count_range();
		test_random_traffic();

		// Drain: every queued outcome must come back, then nothing else may.
		texel_valid <= 1'b0;
		while (normalized_queue.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("alpha_layer_normalizer_unit verification clean");
		end else begin
			$display("alpha_layer_normalizer_unit verification failed");
		end
		$finish;
	end

endmodule
